// ===== src/cpr_pkg.sv =====
// Shared types, widths and codes of the cubic polynomial coordinate remap.
// Depends on nothing; every other file of the block refers to it by scoped names.
package cpr_pkg;

  localparam int unsigned COORD_BITS     = 12;
  localparam int unsigned COEF_FRAC_BITS = 40;
  localparam int unsigned TERMS_PER_AXIS = 10;
  localparam int unsigned SLOT_COUNT     = 2 * TERMS_PER_AXIS;
  localparam int unsigned SLOT_W         = $clog2(SLOT_COUNT);

  // Field widths of the item formats
  localparam int unsigned PIX_W     = 12;
  localparam int unsigned COEF_W    = 48;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned SRC_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Exact datapath widths through the nested evaluation
  localparam int unsigned XS_W  = COORD_BITS + 1;
  localparam int unsigned P1_W  = COEF_W + XS_W;
  localparam int unsigned S2_W  = P1_W + 2;
  localparam int unsigned P3_W  = S2_W + XS_W;
  localparam int unsigned S4_W  = P3_W + 2;
  localparam int unsigned P5_W  = S4_W + XS_W;
  localparam int unsigned ACC_W = P5_W + 2;
  localparam int unsigned RND_W = ACC_W + 1 - COEF_FRAC_BITS;

  localparam int unsigned OFF_CLAMP_LOG = 20;
  localparam int unsigned OFF_W         = OFF_CLAMP_LOG + 1;
  localparam int unsigned SUM_W         = OFF_W + 2;

  // Pipeline depth
  localparam int unsigned AXIS_STAGES  = 6;
  localparam int unsigned ROUND_STAGES = 2;
  localparam int unsigned STAGES       = AXIS_STAGES + ROUND_STAGES + 1;
  localparam int unsigned COEF_STAGES  = AXIS_STAGES - 1;

  // Operation codes
  localparam logic OP_MAP  = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [DIM_W-1:0]     DIM_RESET        = DIM_W'(4096);

  // Term positions within one axis
  localparam int unsigned TERM_1   = 0;
  localparam int unsigned TERM_X   = 1;
  localparam int unsigned TERM_Y   = 2;
  localparam int unsigned TERM_XY  = 3;
  localparam int unsigned TERM_XX  = 4;
  localparam int unsigned TERM_YY  = 5;
  localparam int unsigned TERM_XXY = 6;
  localparam int unsigned TERM_YYX = 7;
  localparam int unsigned TERM_XXX = 8;
  localparam int unsigned TERM_YYY = 9;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [TERMS_PER_AXIS-1:0] coef_set_t;
  typedef coef_t [SLOT_COUNT-1:0] coef_bank_t;

  typedef struct packed {
    logic                     operation;
    logic [PIX_W-1:0]         pixel_x;
    logic [PIX_W-1:0]         pixel_y;
    logic [4:0]               coef_index;
    logic signed [COEF_W-1:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SRC_W-1:0] source_x;
    logic signed [SRC_W-1:0] source_y;
    logic                    outside;
  } out_item_t;

  // Rounded, clamped offset in sign and magnitude form
  typedef struct packed {
    logic             neg;
    logic [OFF_W-1:0] mag;
  } offset_t;

endpackage

// ===== src/cubic_poly_coordinate_remap.sv =====
// Top level of the cubic polynomial coordinate remap.
// Depends on cpr_pkg, cpr_coef_store, cpr_axis_eval and cpr_round.
//
// Use:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries map and load
//   transactions. A map transaction gives one result on the output channel
//   (out_valid_o / out_stall_i / out_data_o); a load transaction writes one
//   coefficient slot and gives no result. Slots above the last are ignored.
//   Configuration port (cfg_valid_i / cfg_ready_o) sets image width (index 0)
//   and height (index 1); it is always ready. Write it only while idle.
// Stages and throughput:
//   A map transaction runs through 9 register stages: products, sums,
//   products, sums, products, final sum, magnitude, round and clamp, place
//   and bound check. One map transaction is taken every cycle while the
//   output does not stall.
//   A load waits while a map transaction sits in the first five stages (the
//   stages that read coefficients).
// Reset:
//   Clears all coefficients (identity map), sets both image dimensions to
//   4096 and empties the pipeline.
// Stall:
//   A stalled result holds in the output register; earlier stages keep
//   advancing into empty slots and hold only once the item ahead holds.
module cubic_poly_coordinate_remap (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  cpr_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output cpr_pkg::out_item_t                out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cpr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cpr_pkg::DIM_W-1:0]         cfg_data_i
);

  localparam int unsigned ST = cpr_pkg::STAGES;
  localparam int unsigned AX = cpr_pkg::AXIS_STAGES;
  localparam int unsigned RS = cpr_pkg::ROUND_STAGES;

  localparam logic signed [cpr_pkg::SUM_W-1:0] SUM_MAX =
    cpr_pkg::SUM_W'(2 ** (cpr_pkg::SRC_W - 1) - 1);
  localparam logic signed [cpr_pkg::SUM_W-1:0] SUM_MIN =
    cpr_pkg::SUM_W'(-(2 ** (cpr_pkg::SRC_W - 1)));

  typedef struct packed {
    logic [cpr_pkg::SRC_W-1:0] src;
    logic                      sat;
  } place_t;

  // Add the rounded offset to the coordinate and saturate to 16 bits
  function automatic place_t place(logic [cpr_pkg::COORD_BITS-1:0] c,
                                   cpr_pkg::offset_t off);
    logic signed [cpr_pkg::SUM_W-1:0] base;
    logic signed [cpr_pkg::SUM_W-1:0] delta;
    logic signed [cpr_pkg::SUM_W-1:0] sum;
    place_t r;
    base  = cpr_pkg::SUM_W'($signed({1'b0, c}));
    delta = cpr_pkg::SUM_W'($signed({1'b0, off.mag}));
    sum   = off.neg ? (base - delta) : (base + delta);
    r.sat = (sum > SUM_MAX) || (sum < SUM_MIN);
    if (sum > SUM_MAX) begin
      r.src = SUM_MAX[cpr_pkg::SRC_W-1:0];
    end else if (sum < SUM_MIN) begin
      r.src = SUM_MIN[cpr_pkg::SRC_W-1:0];
    end else begin
      r.src = sum[cpr_pkg::SRC_W-1:0];
    end
    return r;
  endfunction

  logic [ST:1]   v_q;
  logic [ST+1:1] ready;
  logic          is_load, busy, map_take, load_take;

  logic [cpr_pkg::DIM_W-1:0] width_q, height_q;

  logic [cpr_pkg::COORD_BITS-1:0] x_in, y_in;
  logic [cpr_pkg::COORD_BITS-1:0] xp_q [1:ST-1];
  logic [cpr_pkg::COORD_BITS-1:0] yp_q [1:ST-1];

  cpr_pkg::coef_bank_t bank;
  logic signed [cpr_pkg::ACC_W-1:0] acc_x, acc_y;
  cpr_pkg::offset_t off_x, off_y;
  place_t pl_x, pl_y;
  logic out_side;
  cpr_pkg::out_item_t out_q;

  // Ready ripples back from the output; a stage takes a new item when empty
  // or when the stage after it moves on.
  always_comb begin
    ready[ST+1] = !out_stall_i;
    for (int k = ST; k >= 1; k--) begin
      ready[k] = !v_q[k] || ready[k+1];
    end
  end

  assign is_load   = (in_data_i.operation == cpr_pkg::OP_LOAD);
  // Hold loads while a pixel still has coefficient reads ahead of it
  assign busy      = |v_q[cpr_pkg::COEF_STAGES:1];
  assign map_take  = in_valid_i && !is_load && ready[1];
  assign load_take = in_valid_i && is_load && !busy;
  assign in_stall_o = is_load ? busy : !ready[1];

  assign x_in = in_data_i.pixel_x[cpr_pkg::COORD_BITS-1:0];
  assign y_in = in_data_i.pixel_y[cpr_pkg::COORD_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ready[1]) begin
        v_q[1] <= in_valid_i && !is_load;
      end
      for (int k = 2; k <= ST; k++) begin
        if (ready[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= cpr_pkg::DIM_RESET;
      height_q <= cpr_pkg::DIM_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cpr_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        cpr_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Carry the coordinates to the placement stage
  always_ff @(posedge clk_i) begin
    if (ready[1]) begin
      xp_q[1] <= x_in;
      yp_q[1] <= y_in;
    end
    for (int k = 2; k <= ST - 1; k++) begin
      if (ready[k]) begin
        xp_q[k] <= xp_q[k-1];
        yp_q[k] <= yp_q[k-1];
      end
    end
  end

  cpr_coef_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (load_take),
    .idx_i  (in_data_i.coef_index),
    .data_i (in_data_i.coef_value),
    .bank_o (bank)
  );

  cpr_axis_eval u_eval_x (
    .clk_i  (clk_i),
    .adv_i  (ready[AX:1]),
    .x_i    (x_in),
    .y_i    (y_in),
    .coef_i (bank[cpr_pkg::TERMS_PER_AXIS-1:0]),
    .acc_o  (acc_x)
  );

  cpr_axis_eval u_eval_y (
    .clk_i  (clk_i),
    .adv_i  (ready[AX:1]),
    .x_i    (x_in),
    .y_i    (y_in),
    .coef_i (bank[cpr_pkg::SLOT_COUNT-1:cpr_pkg::TERMS_PER_AXIS]),
    .acc_o  (acc_y)
  );

  cpr_round u_round_x (
    .clk_i (clk_i),
    .adv_i (ready[AX+RS:AX+1]),
    .acc_i (acc_x),
    .off_o (off_x)
  );

  cpr_round u_round_y (
    .clk_i (clk_i),
    .adv_i (ready[AX+RS:AX+1]),
    .acc_i (acc_y),
    .off_o (off_y)
  );

  // Final stage: place, saturate, bound check
  assign pl_x = place(xp_q[ST-1], off_x);
  assign pl_y = place(yp_q[ST-1], off_y);

  assign out_side = pl_x.sat || pl_y.sat
                 || pl_x.src[cpr_pkg::SRC_W-1] || pl_y.src[cpr_pkg::SRC_W-1]
                 || (pl_x.src >= {{(cpr_pkg::SRC_W - cpr_pkg::DIM_W){1'b0}}, width_q})
                 || (pl_y.src >= {{(cpr_pkg::SRC_W - cpr_pkg::DIM_W){1'b0}}, height_q});

  always_ff @(posedge clk_i) begin
    if (ready[ST]) begin
      out_q.source_x <= pl_x.src;
      out_q.source_y <= pl_y.src;
      out_q.outside  <= out_side;
    end
  end

  assign out_valid_o = v_q[ST];
  assign out_data_o  = out_q;

  // A load never overtakes a pixel that still reads coefficients
  a_load_hazard : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && is_load) |-> (v_q[cpr_pkg::COEF_STAGES:1] == '0))
    else $error("load accepted with pixel in coefficient stages");

  // A pixel taken at the first stage occupies it next cycle
  a_enter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_take |=> v_q[1])
    else $error("accepted pixel lost at first stage");

  // A negative source coordinate is always flagged
  a_neg_outside : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.source_x[cpr_pkg::SRC_W-1]
                     || out_data_o.source_y[cpr_pkg::SRC_W-1])) |-> out_data_o.outside)
    else $error("negative source not flagged outside");

  // A result shows up only after leaving the stage before the output
  a_out_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v_q[ST-1]))
    else $error("result without a predecessor stage item");

endmodule

// ===== src/cpr_coef_store.sv =====
// Coefficient register bank: 20 signed entries, cleared at reset.
// Depends on cpr_pkg.
module cpr_coef_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [cpr_pkg::SLOT_W-1:0]    idx_i,
  input  cpr_pkg::coef_t                data_i,
  output cpr_pkg::coef_bank_t           bank_o
);

  cpr_pkg::coef_bank_t bank_q;

  // Slots past the last entry match no register and are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= '0;
    end else begin
      for (int i = 0; i < cpr_pkg::SLOT_COUNT; i++) begin
        if (we_i && (idx_i == cpr_pkg::SLOT_W'(i))) begin
          bank_q[i] <= data_i;
        end
      end
    end
  end

  assign bank_o = bank_q;

endmodule

// ===== src/cpr_axis_eval.sv =====
// Six-stage exact evaluation of one ten-term cubic in nested form.
// Depends on cpr_pkg.
module cpr_axis_eval (
  input  logic                                  clk_i,
  input  logic [cpr_pkg::AXIS_STAGES-1:0]       adv_i,
  input  logic [cpr_pkg::COORD_BITS-1:0]        x_i,
  input  logic [cpr_pkg::COORD_BITS-1:0]        y_i,
  input  cpr_pkg::coef_set_t                    coef_i,
  output logic signed [cpr_pkg::ACC_W-1:0]      acc_o
);

  // off = c0 + x*A + y*B
  //   A = c1 + c3*y + c7*y^2 + x*(c4 + c6*y + c8*x)
  //   B = c2 + y*(c5 + c9*y)
  cpr_pkg::coef_t c [cpr_pkg::TERMS_PER_AXIS];

  logic [cpr_pkg::COORD_BITS-1:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q, x4_q, y4_q;
  logic signed [cpr_pkg::XS_W-1:0] xs0, ys0, xs2, ys2, xs4, ys4;

  logic signed [cpr_pkg::P1_W-1:0]  p6_q, p7_q, p8_q, p9_q;
  logic signed [cpr_pkg::S2_W-1:0]  d_q, f_q, g_q;
  logic signed [cpr_pkg::P3_W-1:0]  dx_q, fy_q, gy_q;
  logic signed [cpr_pkg::S4_W-1:0]  a_q, b_q;
  logic signed [cpr_pkg::P5_W-1:0]  ax_q, by_q;
  logic signed [cpr_pkg::ACC_W-1:0] acc_q;

  for (genvar i = 0; i < cpr_pkg::TERMS_PER_AXIS; i++) begin : g_coef
    assign c[i] = coef_i[i];
  end

  assign xs0 = $signed({1'b0, x_i});
  assign ys0 = $signed({1'b0, y_i});
  assign xs2 = $signed({1'b0, x2_q});
  assign ys2 = $signed({1'b0, y2_q});
  assign xs4 = $signed({1'b0, x4_q});
  assign ys4 = $signed({1'b0, y4_q});

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      p6_q <= cpr_pkg::P1_W'(c[cpr_pkg::TERM_XXY]) * cpr_pkg::P1_W'(ys0);
      p8_q <= cpr_pkg::P1_W'(c[cpr_pkg::TERM_XXX]) * cpr_pkg::P1_W'(xs0);
      p7_q <= cpr_pkg::P1_W'(c[cpr_pkg::TERM_YYX]) * cpr_pkg::P1_W'(ys0);
      p9_q <= cpr_pkg::P1_W'(c[cpr_pkg::TERM_YYY]) * cpr_pkg::P1_W'(ys0);
      x1_q <= x_i;
      y1_q <= y_i;
    end
    if (adv_i[1]) begin
      d_q  <= cpr_pkg::S2_W'(c[cpr_pkg::TERM_XX]) + cpr_pkg::S2_W'(p6_q)
            + cpr_pkg::S2_W'(p8_q);
      f_q  <= cpr_pkg::S2_W'(c[cpr_pkg::TERM_XY]) + cpr_pkg::S2_W'(p7_q);
      g_q  <= cpr_pkg::S2_W'(c[cpr_pkg::TERM_YY]) + cpr_pkg::S2_W'(p9_q);
      x2_q <= x1_q;
      y2_q <= y1_q;
    end
    if (adv_i[2]) begin
      dx_q <= cpr_pkg::P3_W'(d_q) * cpr_pkg::P3_W'(xs2);
      fy_q <= cpr_pkg::P3_W'(f_q) * cpr_pkg::P3_W'(ys2);
      gy_q <= cpr_pkg::P3_W'(g_q) * cpr_pkg::P3_W'(ys2);
      x3_q <= x2_q;
      y3_q <= y2_q;
    end
    if (adv_i[3]) begin
      a_q  <= cpr_pkg::S4_W'(c[cpr_pkg::TERM_X]) + cpr_pkg::S4_W'(dx_q)
            + cpr_pkg::S4_W'(fy_q);
      b_q  <= cpr_pkg::S4_W'(c[cpr_pkg::TERM_Y]) + cpr_pkg::S4_W'(gy_q);
      x4_q <= x3_q;
      y4_q <= y3_q;
    end
    if (adv_i[4]) begin
      ax_q <= cpr_pkg::P5_W'(a_q) * cpr_pkg::P5_W'(xs4);
      by_q <= cpr_pkg::P5_W'(b_q) * cpr_pkg::P5_W'(ys4);
    end
    if (adv_i[5]) begin
      acc_q <= cpr_pkg::ACC_W'(c[cpr_pkg::TERM_1]) + cpr_pkg::ACC_W'(ax_q)
             + cpr_pkg::ACC_W'(by_q);
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== src/cpr_round.sv =====
// Two-stage rounding of an exact offset: magnitude, then half-up and clamp.
// Depends on cpr_pkg.
module cpr_round (
  input  logic                               clk_i,
  input  logic [cpr_pkg::ROUND_STAGES-1:0]   adv_i,
  input  logic signed [cpr_pkg::ACC_W-1:0]   acc_i,
  output cpr_pkg::offset_t                   off_o
);

  localparam logic [cpr_pkg::ACC_W:0] HALF =
    {{cpr_pkg::ACC_W{1'b0}}, 1'b1} << (cpr_pkg::COEF_FRAC_BITS - 1);
  localparam logic [cpr_pkg::RND_W-1:0] CLAMP =
    {{(cpr_pkg::RND_W - 1){1'b0}}, 1'b1} << cpr_pkg::OFF_CLAMP_LOG;

  logic                          neg_q;
  logic [cpr_pkg::ACC_W-1:0]     mag_q;
  logic [cpr_pkg::ACC_W:0]       sum;
  logic [cpr_pkg::RND_W-1:0]     rnd;
  cpr_pkg::offset_t              off_q;

  assign sum = {1'b0, mag_q} + HALF;
  assign rnd = sum[cpr_pkg::ACC_W:cpr_pkg::COEF_FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      neg_q <= acc_i[cpr_pkg::ACC_W-1];
      mag_q <= acc_i[cpr_pkg::ACC_W-1] ? $unsigned(-acc_i) : $unsigned(acc_i);
    end
    if (adv_i[1]) begin
      off_q.neg <= neg_q;
      off_q.mag <= (rnd > CLAMP) ? CLAMP[cpr_pkg::OFF_W-1:0] : rnd[cpr_pkg::OFF_W-1:0];
    end
  end

  assign off_o = off_q;

endmodule
